// ===== sv/plics_pkg.sv =====
// plics_pkg: command and status codes, bin count, cumulative table limits and shared types
// for the piecewise-linear inverse-cdf sampler
// no dependencies
package plics_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam int MAX_POINTS = 256;

	localparam cmd_t CMD_LOAD   = 2'd0;
	localparam cmd_t CMD_BUILD  = 2'd1;
	localparam cmd_t CMD_SAMPLE = 2'd2;

	localparam status_t ST_LOAD   = 2'd0;
	localparam status_t ST_BUILD  = 2'd1;
	localparam status_t ST_SAMPLE = 2'd2;
	localparam status_t ST_ERROR  = 2'd3;

	localparam logic signed [47:0] CUM_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] CUM_MIN = 48'sh8000_0000_0000;

endpackage

// ===== sv/plics_ram.sv =====
// plics_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module plics_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/piecewise_linear_inverse_cdf_sampler.sv =====
// piecewise_linear_inverse_cdf_sampler: top level, sequencer and datapath
// depends on plics_pkg and plics_ram
//
// usage: one request channel (request_valid / request_stall) carries a command
// and its fields; one result channel (result_valid / result_stall) returns one
// status, sample and segment per request. point_count is written with
// point_count_write, by the user only while the block is idle (the block does
// not enforce this); a write clears the built flag. a load writes one bin
// (center and value) and answers in the next cycle. a build reads and captures
// bin 0, then for each further bin reads, captures, multiplies, accumulates and
// steps on; each bin pair with distinct centers also runs the divide and the
// slope write. a sample forms the target, then searches the cumulative entries
// downward from the top segment; a nonzero slope adds a square root and divide,
// a zero slope with a nonzero value adds a divide; the bit-serial divider is shared.
// one request is worked on at a time; a new request is taken once the block is
// idle and the result register is empty or being emptied.
// reset empties the result register, clears the built flag and sets
// point_count to 2; the bin memories are not cleared.
// a stalled result holds its value until taken.
module piecewise_linear_inverse_cdf_sampler
	import plics_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_count_write,
	input  logic [8:0]         point_count,
	input  logic               request_valid,
	output logic               request_stall,
	input  logic [1:0]         command,
	input  logic [7:0]         bin_index,
	input  logic signed [31:0] edge_low,
	input  logic signed [31:0] edge_high,
	input  logic [31:0]        bin_value,
	input  logic [31:0]        random_fraction,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [1:0]         status,
	output logic signed [31:0] sample_value,
	output logic [7:0]         chosen_segment
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_B_RD   = 5'd1;
	localparam logic [4:0] S_B_CAP  = 5'd2;
	localparam logic [4:0] S_B_MUL  = 5'd3;
	localparam logic [4:0] S_B_ACC  = 5'd4;
	localparam logic [4:0] S_B_SLP  = 5'd5;
	localparam logic [4:0] S_B_NEXT = 5'd6;
	localparam logic [4:0] S_S_TOT  = 5'd7;
	localparam logic [4:0] S_S_TM   = 5'd8;
	localparam logic [4:0] S_S_Y1   = 5'd9;
	localparam logic [4:0] S_S_Y2   = 5'd10;
	localparam logic [4:0] S_S_RD   = 5'd11;
	localparam logic [4:0] S_S_CMP  = 5'd12;
	localparam logic [4:0] S_S_MUL  = 5'd13;
	localparam logic [4:0] S_S_P    = 5'd14;
	localparam logic [4:0] S_S_DISC = 5'd15;
	localparam logic [4:0] S_SQRT   = 5'd16;
	localparam logic [4:0] S_S_NUM  = 5'd17;
	localparam logic [4:0] S_DIV    = 5'd18;
	localparam logic [4:0] S_S_OFF  = 5'd19;
	localparam logic [4:0] S_S_X    = 5'd20;

	// control
	logic [4:0]    state_q;
	logic [CW-1:0] i_q;
	logic [6:0]    cnt_q;
	logic          built_q;
	logic [8:0]    pc_q;
	logic          rv_q;
	status_t       st_q;
	logic [31:0]   x_q;
	logic [7:0]    seg_q;

	// datapath
	logic signed [31:0] prev_c_q, cur_c_q;
	logic [31:0]        prev_v_q, cur_v_q;
	logic signed [32:0] dx_q, df_q;
	logic [32:0]        sum_q;
	logic [47:0]        prodh_q;
	logic [49:0]        prodl_q;
	logic signed [47:0] cum_q;
	logic [31:0]        rf_q;
	logic [47:0]        tm_q;
	logic               tneg_q;
	logic [47:0]        yp1_q;
	logic [63:0]        yp0_q;
	logic signed [48:0] y_q;
	logic signed [31:0] a_q, c_q;
	logic [31:0]        v_q;
	logic signed [49:0] d_q;
	logic [63:0]        pl_q, vsq_q;
	logic [48:0]        ph_q;
	logic [80:0]        p_q;
	logic [87:0]        rad_q;
	logic [47:0]        srem_q;
	logic [43:0]        root_q;
	logic               nneg_q;
	logic               zpath_q;
	logic               mode_q;
	logic [63:0]        dvd_q;
	logic [31:0]        dvsr_q;
	logic [32:0]        rem_q;
	logic signed [63:0] off_q;

	// memories
	logic [AW-1:0] rd_addr;
	logic          cv_we;
	logic [AW-1:0] cv_waddr;
	logic [31:0]   c_wdata;
	logic [31:0]   c_rd, v_rd, s_rd;
	logic [47:0]   k_rd;
	logic          k_we, s_we;
	logic [AW-1:0] s_waddr;
	logic [47:0]   k_wdata;
	logic [31:0]   s_wdata;

	logic               accept;
	logic               idx_ok;
	logic [31:0]        n_w;
	logic [CW-1:0]      n_act, n_m1;
	logic [31:0]        dx_mag;
	logic [31:0]        df_mag;
	logic [48:0]        inc49;
	logic [47:0]        inc48;
	logic signed [49:0] acc_sum;
	logic signed [47:0] new_cum;
	logic [63:0]        sq;
	logic               sneg;
	logic [31:0]        slope_sat;
	logic signed [47:0] k_rd_s;
	logic [47:0]        tm_w;
	logic [48:0]        ym;
	logic [31:0]        am;
	logic [48:0]        dm;
	logic [81:0]        disc;
	logic [47:0]        sr_sh, sr_trial;
	logic signed [45:0] num;
	logic [44:0]        nm;
	logic [33:0]        dv_sh;
	logic [63:0]        oq;
	logic               oneg;
	logic signed [63:0] xs;
	logic [31:0]        x_sat;
	logic               push;
	status_t            push_st;
	logic [31:0]        push_x;
	logic [7:0]         push_seg;
	logic signed [32:0] ctr_sum;

	assign request_stall  = (state_q != S_IDLE) || (rv_q && result_stall);
	assign accept         = request_valid && !request_stall;
	assign idx_ok         = {24'd0, bin_index} < 32'(MAX_POINTS);
	assign result_valid   = rv_q;
	assign status         = st_q;
	assign sample_value   = x_q;
	assign chosen_segment = seg_q;

	assign n_w   = ({23'd0, pc_q} < 32'd2) ? 32'd2 :
		(({23'd0, pc_q} > 32'(MAX_POINTS)) ? 32'(MAX_POINTS) : {23'd0, pc_q});
	assign n_act = CW'(n_w);
	assign n_m1  = n_act - CW'(1);

	assign rd_addr  = i_q[AW-1:0];
	assign cv_we    = accept && (command == CMD_LOAD) && idx_ok;
	assign cv_waddr = AW'(bin_index);
	assign ctr_sum  = 33'(edge_low) + 33'(edge_high);
	assign c_wdata  = 32'(ctr_sum >>> 1);

	plics_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_center (
		.clk(clk), .we(cv_we), .waddr(cv_waddr), .wdata(c_wdata),
		.raddr(rd_addr), .rdata(c_rd)
	);

	plics_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_value (
		.clk(clk), .we(cv_we), .waddr(cv_waddr), .wdata(bin_value),
		.raddr(rd_addr), .rdata(v_rd)
	);

	plics_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_slope (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
		.raddr(rd_addr), .rdata(s_rd)
	);

	plics_ram #(.WIDTH(48), .DEPTH(MAX_POINTS)) u_cum (
		.clk(clk), .we(k_we), .waddr(rd_addr), .wdata(k_wdata),
		.raddr(rd_addr), .rdata(k_rd)
	);

	assign k_rd_s = k_rd;

	// build arithmetic
	always_comb begin
		dx_mag  = 32'(dx_q[32] ? -dx_q : dx_q);
		df_mag  = 32'(df_q[32] ? -df_q : df_q);
		inc49   = 49'(prodh_q) + 49'(prodl_q >> 17);
		inc48   = (inc49 > 49'(CUM_MAX)) ? CUM_MAX : inc49[47:0];
		acc_sum = 50'(cum_q) + (dx_q[32] ? -$signed({2'b00, inc48}) : $signed({2'b00, inc48}));
		if (acc_sum > 50'(CUM_MAX)) begin
			new_cum = CUM_MAX;
		end else if (acc_sum < 50'(CUM_MIN)) begin
			new_cum = CUM_MIN;
		end else begin
			new_cum = acc_sum[47:0];
		end
		sq   = (dvd_q > 64'h1_0000_0000) ? 64'h1_0000_0000 : dvd_q;
		sneg = df_q[32] ^ dx_q[32];
		if (!sneg) begin
			slope_sat = (sq >= 64'h8000_0000) ? 32'h7FFF_FFFF : sq[31:0];
		end else begin
			slope_sat = (sq >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-sq);
		end
	end

	// sample arithmetic
	always_comb begin
		tm_w     = 48'(k_rd_s[47] ? -k_rd_s : k_rd_s);
		ym       = 49'(yp1_q) + 49'(yp0_q[63:32]);
		am       = 32'(a_q[31] ? -a_q : a_q);
		dm       = 49'(d_q[49] ? -d_q : d_q);
		if (a_q[31] == d_q[49]) begin
			disc = 82'(vsq_q) + 82'(p_q);
		end else if (81'(vsq_q) >= p_q) begin
			disc = 82'(81'(vsq_q) - p_q);
		end else begin
			disc = '0;
		end
		sr_sh    = {srem_q[45:0], rad_q[87:86]};
		sr_trial = {2'b00, root_q, 2'b01};
		num      = $signed({2'b00, root_q}) - $signed({14'd0, v_q});
		nm       = 45'(num[45] ? -num : num);
		dv_sh    = {rem_q, dvd_q[63]};
		if (zpath_q) begin
			oq   = (dvd_q > 64'h100_0000_0000) ? 64'h100_0000_0000 : dvd_q;
			oneg = d_q[49];
		end else begin
			oq   = dvd_q;
			oneg = nneg_q ^ a_q[31];
		end
		xs = 64'(c_q) + off_q;
		if (xs > 64'sh7FFF_FFFF) begin
			x_sat = 32'h7FFF_FFFF;
		end else if (xs < -64'sh8000_0000) begin
			x_sat = 32'h8000_0000;
		end else begin
			x_sat = xs[31:0];
		end
	end

	// writes and results
	always_comb begin
		k_we     = 1'b0;
		k_wdata  = new_cum;
		s_we     = 1'b0;
		s_waddr  = AW'(i_q - CW'(1));
		s_wdata  = slope_sat;
		push     = 1'b0;
		push_st  = ST_ERROR;
		push_x   = '0;
		push_seg = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (command == CMD_LOAD) begin
						push    = 1'b1;
						push_st = idx_ok ? ST_LOAD : ST_ERROR;
					end else if (command == CMD_SAMPLE) begin
						push = !built_q;
					end else if (command != CMD_BUILD) begin
						push = 1'b1;
					end
				end
			end
			S_B_CAP: begin
				if (i_q == '0) begin
					k_we    = 1'b1;
					k_wdata = '0;
				end
			end
			S_B_ACC: begin
				k_we = 1'b1;
				if (dx_q == '0) begin
					s_we    = 1'b1;
					s_wdata = '0;
				end
			end
			S_B_SLP: s_we = 1'b1;
			S_B_NEXT: begin
				if (i_q == n_m1) begin
					push    = 1'b1;
					push_st = ST_BUILD;
				end
			end
			S_S_X: begin
				push     = 1'b1;
				push_st  = ST_SAMPLE;
				push_x   = x_sat;
				push_seg = 8'(i_q);
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			cnt_q   <= '0;
			built_q <= 1'b0;
			pc_q    <= 9'd2;
			rv_q    <= 1'b0;
		end else begin
			if (push) begin
				rv_q <= 1'b1;
			end else if (rv_q && !result_stall) begin
				rv_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (command == CMD_LOAD) begin
							if (idx_ok) begin
								built_q <= 1'b0;
							end
						end else if (command == CMD_BUILD) begin
							i_q     <= '0;
							state_q <= S_B_RD;
						end else if (command == CMD_SAMPLE && built_q) begin
							i_q     <= n_m1;
							state_q <= S_S_TOT;
						end
					end
				end
				S_B_RD: state_q <= S_B_CAP;
				S_B_CAP: begin
					if (i_q == '0) begin
						i_q     <= CW'(1);
						state_q <= S_B_RD;
					end else begin
						state_q <= S_B_MUL;
					end
				end
				S_B_MUL: state_q <= S_B_ACC;
				S_B_ACC: begin
					if (dx_q != '0) begin
						cnt_q   <= 7'd63;
						state_q <= S_DIV;
					end else begin
						state_q <= S_B_NEXT;
					end
				end
				S_B_SLP: state_q <= S_B_NEXT;
				S_B_NEXT: begin
					if (i_q == n_m1) begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_B_RD;
					end
				end
				S_S_TOT: state_q <= S_S_TM;
				S_S_TM: begin
					i_q     <= n_act - CW'(2);
					state_q <= S_S_Y1;
				end
				S_S_Y1: state_q <= S_S_Y2;
				S_S_Y2: state_q <= S_S_RD;
				S_S_RD: state_q <= S_S_CMP;
				S_S_CMP: begin
					if (i_q != '0 && k_rd_s > y_q) begin
						i_q     <= i_q - CW'(1);
						state_q <= S_S_RD;
					end else begin
						state_q <= S_S_MUL;
					end
				end
				S_S_MUL: begin
					if (a_q != '0) begin
						state_q <= S_S_P;
					end else if (v_q != '0) begin
						cnt_q   <= 7'd63;
						state_q <= S_DIV;
					end else begin
						state_q <= S_S_X;
					end
				end
				S_S_P: state_q <= S_S_DISC;
				S_S_DISC: begin
					cnt_q   <= 7'd43;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						state_q <= S_S_NUM;
					end
				end
				S_S_NUM: begin
					cnt_q   <= 7'd63;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						state_q <= mode_q ? S_S_OFF : S_B_SLP;
					end
				end
				S_S_OFF: state_q <= S_S_X;
				S_S_X: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (point_count_write) begin
				pc_q    <= point_count;
				built_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (push) begin
			st_q  <= push_st;
			x_q   <= push_x;
			seg_q <= push_seg;
		end
		case (state_q)
			S_IDLE: begin
				rf_q   <= random_fraction;
				mode_q <= (command == CMD_SAMPLE);
			end
			S_B_CAP: begin
				if (i_q == '0) begin
					cum_q    <= '0;
					prev_c_q <= c_rd;
					prev_v_q <= v_rd;
				end else begin
					cur_c_q <= c_rd;
					cur_v_q <= v_rd;
					dx_q    <= 33'($signed(c_rd)) - 33'(prev_c_q);
					df_q    <= $signed({1'b0, v_rd}) - $signed({1'b0, prev_v_q});
					sum_q   <= 33'(v_rd) + 33'(prev_v_q);
				end
			end
			S_B_MUL: begin
				prodh_q <= 48'(sum_q * dx_mag[31:17]);
				prodl_q <= 50'(sum_q * dx_mag[16:0]);
			end
			S_B_ACC: begin
				cum_q  <= new_cum;
				dvd_q  <= 64'({df_mag, 16'd0});
				dvsr_q <= dx_mag;
				rem_q  <= '0;
			end
			S_B_NEXT: begin
				prev_c_q <= cur_c_q;
				prev_v_q <= cur_v_q;
			end
			S_S_TM: begin
				tm_q   <= tm_w;
				tneg_q <= k_rd_s[47];
			end
			S_S_Y1: begin
				yp1_q <= 48'(rf_q * tm_q[47:32]);
				yp0_q <= 64'(rf_q * tm_q[31:0]);
			end
			S_S_Y2: y_q <= tneg_q ? -$signed(ym) : $signed(ym);
			S_S_CMP: begin
				a_q <= s_rd;
				v_q <= v_rd;
				c_q <= c_rd;
				d_q <= 50'(y_q) - 50'(k_rd_s);
			end
			S_S_MUL: begin
				pl_q    <= 64'(am * dm[31:0]);
				ph_q    <= 49'(am * dm[48:32]);
				vsq_q   <= 64'(v_q * v_q);
				zpath_q <= 1'b1;
				dvd_q   <= 64'({dm, 16'd0});
				dvsr_q  <= v_q;
				rem_q   <= '0;
				off_q   <= '0;
			end
			S_S_P: p_q <= (81'({ph_q, 32'd0}) + 81'(pl_q)) << 1;
			S_S_DISC: begin
				rad_q  <= 88'(disc);
				srem_q <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				rad_q <= rad_q << 2;
				if (sr_sh >= sr_trial) begin
					srem_q <= sr_sh - sr_trial;
					root_q <= {root_q[42:0], 1'b1};
				end else begin
					srem_q <= sr_sh;
					root_q <= {root_q[42:0], 1'b0};
				end
			end
			S_S_NUM: begin
				zpath_q <= 1'b0;
				nneg_q  <= num[45];
				dvd_q   <= 64'({nm, 16'd0});
				dvsr_q  <= am;
				rem_q   <= '0;
			end
			S_DIV: begin
				if (dv_sh >= {2'b00, dvsr_q}) begin
					rem_q <= 33'(dv_sh - {2'b00, dvsr_q});
					dvd_q <= {dvd_q[62:0], 1'b1};
				end else begin
					rem_q <= dv_sh[32:0];
					dvd_q <= {dvd_q[62:0], 1'b0};
				end
			end
			S_S_OFF: off_q <= oneg ? -$signed(oq) : $signed(oq);
			default: ;
		endcase
	end

	a_div_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> request_stall)
		else $error("request taken while divider busy");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && command == CMD_LOAD && idx_ok) |=> (result_valid && status == ST_LOAD))
		else $error("load did not answer in one cycle");

	a_build_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_B_NEXT && i_q == n_m1) |=> (result_valid && status == ST_BUILD))
		else $error("build end without build status");

	a_clean_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_SAMPLE) |-> (sample_value == '0 && chosen_segment == '0))
		else $error("non-sample result carries sample fields");

endmodule
